FILE: design/dlbp_pkg.sv
package dlbp_pkg;

	localparam int unsigned PERIOD_W = 14;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic                led;
		logic [PERIOD_W-1:0] half_period;
		logic [1:0]          status;
	} out_beat_t;

	localparam logic       OP_BYTE = 1'b0;
	localparam logic       OP_TICK = 1'b1;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_UPDATED  = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	localparam logic [PERIOD_W-1:0] SAT_LIMIT      = 14'd10000;
	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 14'd500;
	localparam logic [PERIOD_W-1:0] MAX_PERIOD     = 14'd9999;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

FILE: design/dlbp_parse.sv
module dlbp_parse #(
	parameter int unsigned LINE_BUFFER_BYTES = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [7:0]                    ch,
	output logic [dlbp_pkg::PERIOD_W-1:0] period_q,
	output logic [dlbp_pkg::PERIOD_W-1:0] period_n,
	output logic [1:0]                    status
);

	localparam int unsigned CW = $clog2(LINE_BUFFER_BYTES);
	localparam logic [CW-1:0] KEEP_MAX = CW'(LINE_BUFFER_BYTES - 1);

	localparam logic [1:0] PH_LEAD   = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	logic [1:0]                    phase_q, phase_n;
	logic                          neg_q, neg_n;
	logic [dlbp_pkg::PERIOD_W-1:0] acc_q, acc_n;
	logic [CW-1:0]                 kept_q, kept_n;

	logic        is_eol, is_ws, is_sign, is_digit, take_digits;
	logic [16:0] acc_x10;

	assign is_eol   = (ch == dlbp_pkg::CH_LF) || (ch == dlbp_pkg::CH_CR);
	assign is_ws    = (ch == dlbp_pkg::CH_SPACE) || (ch == dlbp_pkg::CH_TAB) ||
	                  (ch == dlbp_pkg::CH_VT) || (ch == dlbp_pkg::CH_FF);
	assign is_sign  = (ch == dlbp_pkg::CH_PLUS) || (ch == dlbp_pkg::CH_MINUS);
	assign is_digit = (ch >= dlbp_pkg::CH_ZERO) && (ch <= dlbp_pkg::CH_NINE);
	assign take_digits = (phase_q == PH_DIGITS) ||
	                     ((phase_q == PH_LEAD) && !is_ws && !is_sign);
	// acc * 10 + digit, saturating below
	assign acc_x10 = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {13'd0, ch[3:0] - 4'd0};

	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		acc_n    = acc_q;
		kept_n   = kept_q;
		period_n = period_q;
		status   = dlbp_pkg::ST_NONE;
		if (en) begin
			if (is_eol) begin
				if (kept_q != '0) begin
					if (!neg_q && (acc_q != '0) && (acc_q < dlbp_pkg::SAT_LIMIT)) begin
						period_n = acc_q;
						status   = dlbp_pkg::ST_UPDATED;
					end else begin
						status   = dlbp_pkg::ST_REJECTED;
					end
					phase_n = PH_LEAD;
					neg_n   = 1'b0;
					acc_n   = '0;
					kept_n  = '0;
				end
			end else if (kept_q < KEEP_MAX) begin
				kept_n = kept_q + 1'b1;
				if ((phase_q == PH_LEAD) && is_sign) begin
					neg_n   = (ch == dlbp_pkg::CH_MINUS);
					phase_n = PH_DIGITS;
				end
				if (take_digits) begin
					if (is_digit) begin
						phase_n = PH_DIGITS;
						acc_n   = (acc_x10 > {3'b000, dlbp_pkg::SAT_LIMIT}) ?
						          dlbp_pkg::SAT_LIMIT : acc_x10[dlbp_pkg::PERIOD_W-1:0];
					end else begin
						phase_n = PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			kept_q   <= '0;
			period_q <= dlbp_pkg::DEFAULT_PERIOD;
		end else begin
			phase_q  <= phase_n;
			neg_q    <= neg_n;
			acc_q    <= acc_n;
			kept_q   <= kept_n;
			period_q <= period_n;
		end
	end

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= dlbp_pkg::SAT_LIMIT)
		else $error("accumulator above saturation limit");

	a_kept_max: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KEEP_MAX)
		else $error("line length above capacity");

	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		(period_q != '0) && (period_q <= dlbp_pkg::MAX_PERIOD))
		else $error("period setting out of range");

endmodule

FILE: design/decimal_line_blink_period_control_core.sv
// Result beat is registered and valid in the cycle after the input beat is accepted.
// Throughput: one item per cycle; in_ready stays high while the output
// register is empty or being drained in the same cycle.
// Reset (arst_n low, asynchronous): line cleared, half-period 500 ms,
// LED on with the millisecond count at zero, no result pending.
module decimal_line_blink_period_control_core #(
	parameter int unsigned LINE_BUFFER_BYTES = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dlbp_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dlbp_pkg::out_beat_t out_data
);

	logic                          accept, tick;
	logic [dlbp_pkg::PERIOD_W-1:0] period_q, period_n;
	logic [1:0]                    status;
	logic [dlbp_pkg::PERIOD_W-1:0] elapsed_q, elapsed_n, active_q, active_n, elapsed_inc;
	logic                          led_q, led_n;
	logic                          out_valid_q;
	dlbp_pkg::out_beat_t           res_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (in_data.op == dlbp_pkg::OP_TICK);

	dlbp_parse #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept && (in_data.op == dlbp_pkg::OP_BYTE)),
		.ch      (in_data.rx_byte),
		.period_q(period_q),
		.period_n(period_n),
		.status  (status)
	);

	assign elapsed_inc = elapsed_q + 1'b1;

	always_comb begin
		elapsed_n = elapsed_q;
		active_n  = active_q;
		led_n     = led_q;
		if (tick) begin
			if (elapsed_inc >= active_q) begin
				elapsed_n = '0;
				active_n  = period_q;
				led_n     = !led_q;
			end else begin
				elapsed_n = elapsed_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			active_q    <= dlbp_pkg::DEFAULT_PERIOD;
			led_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			elapsed_q <= elapsed_n;
			active_q  <= active_n;
			led_q     <= led_n;
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.led         <= led_n;
			res_q.half_period <= period_n;
			res_q.status      <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	a_elapsed_lt_active: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q < active_q)
		else $error("millisecond count reached half-period length");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q != '0) && (active_q <= dlbp_pkg::MAX_PERIOD))
		else $error("active half-period out of range");

	a_tick_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (res_q.status == dlbp_pkg::ST_NONE))
		else $error("tick produced a nonzero status");

	a_out_led: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_valid_q && (res_q.led == led_q) && (res_q.half_period == period_q)))
		else $error("result beat does not match state");

endmodule
